// ===== rtl/core/mhpq_pkg.sv =====
package mhpq_pkg;

	// Number of entries the queue can hold.
	localparam int DEPTH = 256;
	// Width of the entry count, wide enough to hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Width of one stored value.
	localparam int VAL_W = 32;

	// Operation codes carried on the mode input.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Command broadcast to every cell of the chain in the cycle of a transfer.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== rtl/core/mhpq_cell.sv =====
module mhpq_cell (
	input  logic                       clk,
	input  mhpq_pkg::cell_ctl_t        ctl,
	input  logic                       occupied,
	input  logic                       prev_ge,
	input  logic [mhpq_pkg::VAL_W-1:0] prev_data,
	input  logic [mhpq_pkg::VAL_W-1:0] next_data,
	output logic                       ge,
	output logic [mhpq_pkg::VAL_W-1:0] data
);
	import mhpq_pkg::*;

	logic [VAL_W-1:0] data_q;

	// The chain is kept sorted in descending order, so the cells that hold a
	// value at least as large as the new one form a prefix.
	assign ge   = occupied && (data_q >= ctl.value);
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!ge) begin
				data_q <= prev_ge ? ctl.value : prev_data;
			end
		end else if (ctl.rem) begin
			data_q <= next_data;
		end
	end

endmodule

// ===== rtl/core/max_heap_priority_queue.sv =====
// Channel   | Signals                                            | Direction | Flow control
// ----------+----------------------------------------------------+-----------+---------------
// command   | start, busy, mode, value                           | in        | start & !busy
// result    | done, removed_value, removed_valid, entry_count,   | out       | done strobe,
//           | status                                             |           | no back-pressure
//
// Every command is served by the single parallel compare-and-shift across the cell row: the
// chain of cells updates at the edge that completes the transfer, and the result strobe
// follows in the next cycle.
// A new command may be transferred in every cycle, so busy stays low.
// Reset clears the entry count and the result strobe; stored values are not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module max_heap_priority_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         mode,
	input  logic [mhpq_pkg::VAL_W-1:0]   value,
	output logic                         done,
	output logic [mhpq_pkg::VAL_W-1:0]   removed_value,
	output logic                         removed_valid,
	output logic [mhpq_pkg::CNT_W-1:0]   entry_count,
	output logic [1:0]                   status
);
	import mhpq_pkg::*;

	// The queue is held as a row of cells sorted in descending order. Cell zero
	// always holds the maximum, so a remove takes it directly and every other
	// cell takes the value of its lower neighbor. An insert compares the new
	// value against every occupied cell at once; cells holding a larger or equal
	// value keep it, the first smaller cell takes the new value and every cell
	// below it takes the value of its upper neighbor. Only the cells below the
	// entry count are ever read, so the stored values need no reset.

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             full;
	logic             empty;
	cell_ctl_t        ctl;

	logic [VAL_W-1:0] cell_data [DEPTH];
	logic             cell_ge   [DEPTH];
	logic             cell_occ  [DEPTH];

	logic             done_q;
	logic [VAL_W-1:0] removed_value_q;
	logic             removed_valid_q;
	logic [CNT_W-1:0] entry_count_q;
	logic [1:0]       status_q;

	// One command completes per cycle, so the block never holds a command off.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// The cells are told to move only when the command really changes the queue.
	assign ctl.ins   = accept && (mode == MODE_INSERT) && !full;
	assign ctl.rem   = accept && (mode == MODE_REMOVE) && !empty;
	assign ctl.value = value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             prev_ge_w;
		logic [VAL_W-1:0] prev_data_w;
		logic [VAL_W-1:0] next_data_w;

		assign cell_occ[i] = (count_q > CNT_W'(i));

		// The head cell has no upper neighbor: it behaves as if the cell above
		// it held a larger value, so a new maximum lands there.
		if (i == 0) begin : g_head
			assign prev_ge_w   = 1'b1;
			assign prev_data_w = '0;
		end else begin : g_body
			assign prev_ge_w   = cell_ge[i-1];
			assign prev_data_w = cell_data[i-1];
		end

		// The tail cell has no lower neighbor; what it takes on a remove lies
		// beyond the new entry count and is never read.
		if (i == DEPTH - 1) begin : g_tail
			assign next_data_w = '0;
		end else begin : g_link
			assign next_data_w = cell_data[i+1];
		end

		mhpq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (cell_occ[i]),
			.prev_ge   (prev_ge_w),
			.prev_data (prev_data_w),
			.next_data (next_data_w),
			.ge        (cell_ge[i]),
			.data      (cell_data[i])
		);
	end

	// Entry count and result strobe are control state and are reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Result payload is captured in the cycle of the transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value_q <= ctl.rem ? cell_data[0] : '0;
			removed_valid_q <= ctl.rem;
			if (ctl.ins) begin
				entry_count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				entry_count_q <= count_q - CNT_W'(1);
			end else begin
				entry_count_q <= count_q;
			end
			if (mode == MODE_INSERT) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else begin
				status_q <= empty ? ST_EMPTY : ST_OK;
			end
		end
	end

	assign done          = done_q;
	assign removed_value = removed_value_q;
	assign removed_valid = removed_valid_q;
	assign entry_count   = entry_count_q;
	assign status        = status_q;

	// Every transfer yields exactly one result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("command transfer without a result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without a command transfer");

	// The count never runs past the capacity of the chain.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds capacity");

	// The head of the chain holds the maximum of the two leading entries.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_data[0] >= cell_data[1]))
		else $error("head cell is not the maximum");

	// A real removal is always reported with good status, and an empty status
	// always comes with a zero entry count.
	a_valid_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && removed_valid) |-> (status == ST_OK))
		else $error("removed value flagged with bad status");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (entry_count == '0))
		else $error("empty status with nonzero count");

endmodule
